// ===== rtl/rect_segment_collision_test_core_macros.svh =====
// Assertion macros shared by the collision test RTL.
`ifndef RECT_SEGMENT_COLLISION_TEST_CORE_MACROS_SVH
`define RECT_SEGMENT_COLLISION_TEST_CORE_MACROS_SVH

// Same-cycle implication, checked while the reset is low.
`define RSCT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while the disable term is low.
`define RSCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rsct_pkg.sv =====
// Types and helpers shared by the rectangle and segment hit tester.
`timescale 1ns / 1ps

package rsct_pkg;

   // Test selector carried on the request tuser.
   typedef enum logic [1:0] {
      OP_RECT_RECT  = 2'd0,
      OP_RECT_POINT = 2'd1,
      OP_RECT_SEG   = 2'd2,
      OP_SEG_SEG    = 2'd3
   } op_type;

   // Result channel width: the hit flag padded to one byte.
   localparam int OUT_DATA_WIDTH = 8;

   // Sign of a cross product; zero when neither bit is set.
   typedef struct packed {
      logic neg;
      logic pos;
   } sign_type;

   // Comparison results that do not need a multiplier.
   typedef struct packed {
      logic rr_hit;
      logic pt_inside;
      logic dx_nz;
      logic dy_nz;
      logic top_opp;
      logic bot_opp;
      logic left_opp;
      logic right_opp;
   } flags_type;

   // True when two signs are strictly opposite.
   function automatic logic sign_opposite(input sign_type a, input sign_type b);
      return (a.neg & b.pos) | (a.pos & b.neg);
   endfunction

endpackage

// ===== rtl/rect_segment_collision_test_core.sv =====
// Four-stage pipelined 2D hit tester for rectangles, points and segments.
// A request passes stage registers one to four; the four cross-product lanes are fully pipelined.
// Throughput: one transfer per cycle unless the output stalls.
// Each stage holds while its successor is full and stalled, so nothing is dropped.
// Synchronous active-high reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps

`include "rect_segment_collision_test_core_macros.svh"

module rect_segment_collision_test_core
   import rsct_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0: first_x0, first_y0, first_x1, first_y1,
   // second_x0, second_y0, second_x1, second_y1, then zero padding.
   input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // Fields from bit 0: operation.
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: hit, then zero padding.
   output logic [OUT_DATA_WIDTH-1:0]         rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam int W      = COORD_WIDTH;
   localparam int PROD_W = 2*COORD_WIDTH + 2;
   localparam int LANES  = 4;

   // Difference of two coordinates, one bit wider so it never overflows.
   function automatic logic signed [W:0] diff_ext(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      return $signed({a[W-1], a}) - $signed({b[W-1], b});
   endfunction

   // Closed-interval membership with either bound order.
   function automatic logic in_range(input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b,
                                     input logic signed [W-1:0] c);
      return (b <= c) ? ((b <= a) && (a <= c)) : ((c <= a) && (a <= b));
   endfunction

   // Two values lying strictly on opposite sides of a level.
   function automatic logic straddle(input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b,
                                     input logic signed [W-1:0] f);
      return ((a < f) && (b > f)) || ((a > f) && (b < f));
   endfunction

   // Stage handshake: a stage moves when it is empty or its successor moves.
   logic en1, en2, en3, en4;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   assign en4 = !s4_valid_ff || rsp_tready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_tready = en1;

   // Unpack the request coordinates.
   logic signed [W-1:0] fx0, fy0, fx1, fy1, sx0, sy0, sx1, sy1;

   assign fx0 = $signed(req_tdata[0*W +: W]);
   assign fy0 = $signed(req_tdata[1*W +: W]);
   assign fx1 = $signed(req_tdata[2*W +: W]);
   assign fy1 = $signed(req_tdata[3*W +: W]);
   assign sx0 = $signed(req_tdata[4*W +: W]);
   assign sy0 = $signed(req_tdata[5*W +: W]);
   assign sx1 = $signed(req_tdata[6*W +: W]);
   assign sy1 = $signed(req_tdata[7*W +: W]);

   // Stage 1: comparisons and the differences that feed each cross-product lane.
   // Lane k tests point m against the line a->b. Lanes 0 and 1 always use the
   // second segment as the line; lanes 2 and 3 use the first segment for the
   // segment pair test and the second segment for the rectangle corners.
   logic signed [W-1:0] lane_ax [LANES];
   logic signed [W-1:0] lane_ay [LANES];
   logic signed [W-1:0] lane_bx [LANES];
   logic signed [W-1:0] lane_by [LANES];
   logic signed [W-1:0] lane_mx [LANES];
   logic signed [W-1:0] lane_my [LANES];
   logic                seg_pair;

   assign seg_pair = (op_type'(req_tuser) == OP_SEG_SEG);

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lane_ax[k] = sx0;
         lane_ay[k] = sy0;
         lane_bx[k] = sx1;
         lane_by[k] = sy1;
      end
      if (seg_pair) begin
         for (int k = 2; k < LANES; k++) begin
            lane_ax[k] = fx0;
            lane_ay[k] = fy0;
            lane_bx[k] = fx1;
            lane_by[k] = fy1;
         end
      end
      lane_mx[0] = fx0;
      lane_my[0] = fy0;
      lane_mx[1] = fx1;
      lane_my[1] = seg_pair ? fy1 : fy0;
      lane_mx[2] = seg_pair ? sx0 : fx0;
      lane_my[2] = seg_pair ? sy0 : fy1;
      lane_mx[3] = seg_pair ? sx1 : fx1;
      lane_my[3] = seg_pair ? sy1 : fy1;
   end

   flags_type           s1_flags_in;
   logic signed [W:0]   s1_ex_in  [LANES];
   logic signed [W:0]   s1_ey_in  [LANES];
   logic signed [W:0]   s1_dmx_in [LANES];
   logic signed [W:0]   s1_dmy_in [LANES];

   always_comb begin
      s1_flags_in.rr_hit = (in_range(fx0, sx0, sx1) || in_range(fx1, sx0, sx1) ||
                            in_range(sx0, fx0, fx1)) &&
                           (in_range(fy0, sy0, sy1) || in_range(fy1, sy0, sy1) ||
                            in_range(sy0, fy0, fy1));
      s1_flags_in.pt_inside = in_range(sx0, fx0, fx1) && in_range(sy0, fy0, fy1);
      s1_flags_in.dx_nz     = (fx1 != fx0);
      s1_flags_in.dy_nz     = (fy1 != fy0);
      s1_flags_in.top_opp   = straddle(sy0, sy1, fy0);
      s1_flags_in.bot_opp   = straddle(sy0, sy1, fy1);
      s1_flags_in.left_opp  = straddle(sx0, sx1, fx0);
      s1_flags_in.right_opp = straddle(sx0, sx1, fx1);
      for (int k = 0; k < LANES; k++) begin
         s1_ex_in[k]  = diff_ext(lane_bx[k], lane_ax[k]);
         s1_ey_in[k]  = diff_ext(lane_by[k], lane_ay[k]);
         s1_dmx_in[k] = diff_ext(lane_mx[k], lane_ax[k]);
         s1_dmy_in[k] = diff_ext(lane_my[k], lane_ay[k]);
      end
   end

   op_type              s1_op_ff;
   flags_type           s1_flags_ff;
   logic signed [W:0]   s1_ex_ff  [LANES];
   logic signed [W:0]   s1_ey_ff  [LANES];
   logic signed [W:0]   s1_dmx_ff [LANES];
   logic signed [W:0]   s1_dmy_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff    <= op_type'(req_tuser);
         s1_flags_ff <= s1_flags_in;
         s1_ex_ff    <= s1_ex_in;
         s1_ey_ff    <= s1_ey_in;
         s1_dmx_ff   <= s1_dmx_in;
         s1_dmy_ff   <= s1_dmy_in;
      end
   end

   // Stage 2: the two products of each cross product.
   logic signed [PROD_W-1:0] s2_p_in [LANES];
   logic signed [PROD_W-1:0] s2_q_in [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s2_p_in[k] = s1_ex_ff[k] * s1_dmy_ff[k];
         s2_q_in[k] = s1_dmx_ff[k] * s1_ey_ff[k];
      end
   end

   op_type                   s2_op_ff;
   flags_type                s2_flags_ff;
   logic signed [PROD_W-1:0] s2_p_ff [LANES];
   logic signed [PROD_W-1:0] s2_q_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_ff    <= s1_op_ff;
         s2_flags_ff <= s1_flags_ff;
         s2_p_ff     <= s2_p_in;
         s2_q_ff     <= s2_q_in;
      end
   end

   // Stage 3: subtract and keep only the sign. Both products stay below
   // 2^(2W) in magnitude, so the difference fits the product width.
   logic signed [PROD_W-1:0] s3_cross [LANES];
   sign_type                 s3_sign_in [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s3_cross[k]       = s2_p_ff[k] - s2_q_ff[k];
         s3_sign_in[k].neg = s3_cross[k][PROD_W-1];
         s3_sign_in[k].pos = !s3_cross[k][PROD_W-1] && (s3_cross[k] != '0);
      end
   end

   op_type    s3_op_ff;
   flags_type s3_flags_ff;
   sign_type  s3_sign_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_op_ff    <= s2_op_ff;
         s3_flags_ff <= s2_flags_ff;
         s3_sign_ff  <= s3_sign_in;
      end
   end

   // Stage 4: combine the signs into the hit flag. A rectangle edge is
   // crossed when its two corners lie strictly on opposite sides of the
   // segment and the segment endpoints lie strictly on opposite sides of
   // the edge, which for an axis-aligned edge of nonzero length is a plain
   // straddle of the edge's level.
   logic s4_hit_in;
   logic cross_top, cross_left, cross_right, cross_bottom;

   always_comb begin
      cross_top    = s3_flags_ff.dx_nz && s3_flags_ff.top_opp &&
                     sign_opposite(s3_sign_ff[0], s3_sign_ff[1]);
      cross_left   = s3_flags_ff.dy_nz && s3_flags_ff.left_opp &&
                     sign_opposite(s3_sign_ff[0], s3_sign_ff[2]);
      cross_right  = s3_flags_ff.dy_nz && s3_flags_ff.right_opp &&
                     sign_opposite(s3_sign_ff[1], s3_sign_ff[3]);
      cross_bottom = s3_flags_ff.dx_nz && s3_flags_ff.bot_opp &&
                     sign_opposite(s3_sign_ff[2], s3_sign_ff[3]);
      unique case (s3_op_ff)
         OP_RECT_RECT:  s4_hit_in = s3_flags_ff.rr_hit;
         OP_RECT_POINT: s4_hit_in = s3_flags_ff.pt_inside;
         OP_RECT_SEG:   s4_hit_in = s3_flags_ff.pt_inside || cross_top || cross_left ||
                                    cross_right || cross_bottom;
         OP_SEG_SEG:    s4_hit_in = sign_opposite(s3_sign_ff[0], s3_sign_ff[1]) &&
                                    sign_opposite(s3_sign_ff[2], s3_sign_ff[3]);
         default:       s4_hit_in = 1'b0;
      endcase
   end

   logic s4_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_hit_ff <= s4_hit_in;
      end
   end

   // Result channel.
   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {{(OUT_DATA_WIDTH-1){1'b0}}, s4_hit_ff};

   // Checks on the pipeline control.
   `RSCT_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, s1_valid_ff, "accepted transfer did not enter stage one")
   `RSCT_ASSERT_NEXT(a_stage3_moves, clock, reset, s3_valid_ff && en4, s4_valid_ff, "stage three item lost on its way to the output")
   `RSCT_ASSERT_IMPLY(a_full_when_blocked, clock, reset, !req_tready, s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_tready, "request blocked while a stage was free")
   `RSCT_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid && !s1_valid_ff, "reset left a valid item in the pipeline")

endmodule
